>>> hdl/grfa_pkg.sv
// ----------------------------------------------------------------------------
// grfa_pkg
// Shared types, codes and the footprint scaling function of the grid
// rectangle first-fit allocator.
// ----------------------------------------------------------------------------
package grfa_pkg;

  localparam int MAX_GRID_W = 16;
  localparam int MAX_GRID_H = 16;
  localparam int MAX_RECTS  = 64;

  localparam int SLOT_W = $clog2(MAX_RECTS);
  localparam int GX_W   = $clog2(MAX_GRID_W);
  localparam int GY_W   = $clog2(MAX_GRID_H);
  localparam int CELLS  = MAX_GRID_W * MAX_GRID_H;
  localparam int CELL_W = $clog2(CELLS);
  localparam int OWN_W  = SLOT_W + 1;

  localparam logic [8:0] SCALE_MIN = 9'd26;
  localparam logic [8:0] SCALE_MAX = 9'd256;

  typedef enum logic [2:0] {
    OP_PLACE  = 3'd0,
    OP_REMOVE = 3'd1,
    OP_MOVE   = 3'd2,
    OP_ROTATE = 3'd3,
    OP_QUERY  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_ROOM = 3'd1,
    ST_BAD     = 3'd2,
    ST_ROT     = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_GRID_W = 2'd0,
    REG_GRID_H = 2'd1,
    REG_SCALE  = 2'd2,
    REG_ROT_EN = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RB_RD, S_RB_EFF, S_RB_WR, S_LOAD_RD, S_LOAD,
    S_FIT_EFF, S_FIT_BND, S_FIT_RD, S_FIT_CHK, S_POST,
    S_Q_RD, S_Q_TBL, S_Q_DONE, S_EMIT
  } state_t;

  // Scaled footprint: (s * k + 128) >> 8, k clamped to 26..256, minimum 1.
  function automatic logic [4:0] eff_size(input logic [4:0] s, input logic [8:0] scale);
    logic [8:0]  k;
    logic [13:0] p;
    logic [4:0]  e;
    k = scale;
    if (k < SCALE_MIN) k = SCALE_MIN;
    if (k > SCALE_MAX) k = SCALE_MAX;
    p = 14'({9'd0, s} * {5'd0, k}) + 14'd128;
    e = p[12:8];
    return (e == 5'd0) ? 5'd1 : e;
  endfunction

endpackage

>>> hdl/grid_rect_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// grid_rect_first_fit_allocator
// Slot table and cell-owner map for first-fit rectangle placement on a grid.
// ----------------------------------------------------------------------------
// Flow: a request reads its slot (S_LOAD_RD, S_LOAD); a footprint check runs S_FIT_EFF,
//   S_FIT_BND and S_FIT_RD/S_FIT_CHK per cell into S_POST; a query runs S_Q_RD to S_Q_DONE.
// First-fit scan: up to 256 candidates, each a bound test plus a read and check per cell checked.
// After a table change or a configuration write the next request first rebuilds
//   the map: it clears every cell, then paints each valid slot cell by cell.
// Throughput: one request at a time; a stalled result holds S_EMIT. Reset: slots invalid.
module grid_rect_first_fit_allocator (
  input  logic        clk,
  input  logic        rst,
  // request: op[2:0] slot[8:3] pos_x[12:9] pos_y[16:13] size_w[21:17]
  //          size_h[26:22] item_rotatable[27], zero above
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // result: status[2:0] result_slot[8:3] result_x[12:9] result_y[18:13]
  //         result_w[23:19] result_h[28:24], zero above
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import grfa_pkg::*;

  localparam logic [OWN_W-1:0] IGN_NONE = OWN_W'(MAX_RECTS);

  state_t state, state_next;

  // configuration
  logic [4:0] grid_width, grid_height;
  logic [8:0] size_scale;
  logic       rotation_enabled;
  logic [4:0] gw, gh;
  logic       list_mode;

  assign gw = (grid_width  > 5'(MAX_GRID_W)) ? 5'(MAX_GRID_W) : grid_width;
  assign gh = (grid_height > 5'(MAX_GRID_H)) ? 5'(MAX_GRID_H) : grid_height;
  assign list_mode = (gw == 5'd0) || (gh == 5'd0);

  // memories: slot table {x, y, w, h} and cell owner map (slot + 1, 0 empty)
  logic [17:0]      rect_mem [MAX_RECTS];
  logic [OWN_W-1:0] map_mem  [CELLS];
  logic [17:0]      rect_rdata;
  logic [OWN_W-1:0] map_rdata;
  logic [SLOT_W-1:0] rect_raddr, rect_waddr;
  logic [17:0]       rect_wdata;
  logic              rect_we;
  logic [CELL_W-1:0] map_raddr, map_waddr;
  logic [OWN_W-1:0]  map_wdata;
  logic              map_we;

  always_ff @(posedge clk) begin
    if (rect_we) rect_mem[rect_waddr] <= rect_wdata;
    rect_rdata <= rect_mem[rect_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata <= map_mem[map_raddr];
  end

  logic [GX_W-1:0] rd_x, rd_y;
  logic [4:0]      rd_w, rd_h;
  assign rd_x = rect_rdata[17:14];
  assign rd_y = rect_rdata[13:10];
  assign rd_w = rect_rdata[9:5];
  assign rd_h = rect_rdata[4:0];

  // control and datapath registers
  logic [MAX_RECTS-1:0] valid, valid_next;
  logic dirty, dirty_next;
  logic [2:0] req_op, req_op_next;
  logic [SLOT_W-1:0] req_slot, req_slot_next;
  logic [GX_W-1:0] req_x, req_x_next, req_y, req_y_next;
  logic [4:0] req_w, req_w_next, req_h, req_h_next;
  logic req_rot, req_rot_next;
  logic [GX_W-1:0] tx, tx_next, ty, ty_next;
  logic [4:0] tw, tw_next, th, th_next;
  logic [SLOT_W-1:0] free_slot, free_slot_next;
  logic [CELL_W-1:0] clr, clr_next;
  logic [SLOT_W-1:0] rs, rs_next;
  logic [GX_W-1:0] rx, rx_next, ry, ry_next;
  logic [4:0] rew, rew_next, reh, reh_next;
  logic [4:0] dx, dx_next, dy, dy_next;
  logic [GX_W-1:0] fx, fx_next, fy, fy_next;
  logic [4:0] fw, fw_next, fh, fh_next, few, few_next, feh, feh_next;
  logic [OWN_W-1:0] fign, fign_next;
  logic fit_ok, fit_ok_next;
  logic scanning, scanning_next;
  logic [SLOT_W-1:0] q_slot, q_slot_next;
  // staged result and output register
  logic [28:0] res, res_next;
  logic        out_valid, out_valid_next;
  logic [28:0] out_data, out_data_next;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_data};

  // lowest free slot
  logic [SLOT_W-1:0] first_free;
  logic              any_free;
  always_comb begin
    first_free = '0;
    any_free   = 1'b0;
    for (int i = MAX_RECTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        first_free = SLOT_W'(i);
        any_free   = 1'b1;
      end
    end
  end

  function automatic logic [28:0] pack_ok(input logic [SLOT_W-1:0] s, input logic [3:0] x,
                                          input logic [3:0] y, input logic [4:0] w,
                                          input logic [4:0] h);
    return {h, w, {2'd0, y}, x, s, ST_OK};
  endfunction

  function automatic logic [28:0] pack_fail(input status_t st);
    return {26'd0, st};
  endfunction

  logic [5:0]       rb_xx, rb_yy;
  logic [OWN_W-1:0] own;
  logic             have;

  assign rb_xx = {2'd0, rx} + {1'b0, dx};
  assign rb_yy = {2'd0, ry} + {1'b0, dy};
  assign own   = map_rdata;
  assign have  = valid[req_slot];

  always_comb begin
    state_next     = state;
    valid_next     = valid;
    dirty_next     = dirty;
    req_op_next    = req_op;
    req_slot_next  = req_slot;
    req_x_next     = req_x;
    req_y_next     = req_y;
    req_w_next     = req_w;
    req_h_next     = req_h;
    req_rot_next   = req_rot;
    tx_next = tx; ty_next = ty; tw_next = tw; th_next = th;
    free_slot_next = free_slot;
    clr_next = clr;
    rs_next  = rs;
    rx_next = rx; ry_next = ry; rew_next = rew; reh_next = reh;
    dx_next = dx; dy_next = dy;
    fx_next = fx; fy_next = fy; fw_next = fw; fh_next = fh;
    few_next = few; feh_next = feh; fign_next = fign;
    fit_ok_next   = fit_ok;
    scanning_next = scanning;
    q_slot_next   = q_slot;
    res_next      = res;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    rect_raddr = req_slot;
    rect_we    = 1'b0;
    rect_waddr = req_slot;
    rect_wdata = {req_x, req_y, req_w, req_h};
    map_raddr  = {fy + dy[GY_W-1:0], fx + dx[GX_W-1:0]};
    map_we     = 1'b0;
    map_waddr  = clr;
    map_wdata  = '0;

    if (out_valid && m_axis_tready) out_valid_next = 1'b0;
    // configuration changes the footprint layout: mark the map stale
    if (cfg_we) dirty_next = 1'b1;

    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_op_next   = s_axis_tdata[2:0];
          req_slot_next = s_axis_tdata[8:3];
          req_x_next    = s_axis_tdata[12:9];
          req_y_next    = s_axis_tdata[16:13];
          req_w_next    = s_axis_tdata[21:17];
          req_h_next    = s_axis_tdata[26:22];
          req_rot_next  = s_axis_tdata[27];
          clr_next      = '0;
          state_next    = dirty ? S_CLR : S_LOAD_RD;
        end
      end
      // clear the map, then paint valid slots in ascending order
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr;
        clr_next  = clr + 1'b1;
        if (clr == CELL_W'(CELLS - 1)) begin
          rs_next    = '0;
          state_next = S_RB_RD;
        end
      end
      S_RB_RD: begin
        rect_raddr = rs;
        if (valid[rs]) begin
          state_next = S_RB_EFF;
        end else if (rs == SLOT_W'(MAX_RECTS - 1)) begin
          dirty_next = 1'b0;
          state_next = S_LOAD_RD;
        end else begin
          rs_next = rs + 1'b1;
        end
      end
      S_RB_EFF: begin
        rx_next  = rd_x;
        ry_next  = rd_y;
        rew_next = eff_size(rd_w, size_scale);
        reh_next = eff_size(rd_h, size_scale);
        dx_next  = '0;
        dy_next  = '0;
        state_next = S_RB_WR;
      end
      S_RB_WR: begin
        map_waddr = {rb_yy[GY_W-1:0], rb_xx[GX_W-1:0]};
        map_wdata = {1'b0, rs} + 1'b1;
        map_we    = (rb_xx < {1'b0, gw}) && (rb_yy < {1'b0, gh});
        if (dx == rew - 5'd1) begin
          dx_next = '0;
          if (dy == reh - 5'd1) begin
            if (rs == SLOT_W'(MAX_RECTS - 1)) begin
              dirty_next = 1'b0;
              state_next = S_LOAD_RD;
            end else begin
              rs_next    = rs + 1'b1;
              state_next = S_RB_RD;
            end
          end else begin
            dy_next = dy + 5'd1;
          end
        end else begin
          dx_next = dx + 5'd1;
        end
      end
      S_LOAD_RD: begin
        rect_raddr = req_slot;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        tx_next = rd_x; ty_next = rd_y; tw_next = rd_w; th_next = rd_h;
        free_slot_next = first_free;
        scanning_next  = 1'b0;
        state_next     = S_EMIT;
        case (req_op)
          OP_PLACE: begin
            if (!any_free) begin
              res_next = pack_fail(ST_NO_ROOM);
            end else begin
              fx_next = req_x; fy_next = req_y; fw_next = req_w; fh_next = req_h;
              fign_next  = IGN_NONE;
              state_next = S_FIT_EFF;
            end
          end
          OP_REMOVE: begin
            if (!have) begin
              res_next = pack_fail(ST_BAD);
            end else begin
              res_next = pack_ok(req_slot, rd_x, rd_y, rd_w, rd_h);
              valid_next[req_slot] = 1'b0;
              dirty_next = 1'b1;
            end
          end
          OP_MOVE: begin
            if (!have) begin
              res_next = pack_fail(ST_BAD);
            end else begin
              fx_next = req_x; fy_next = req_y; fw_next = rd_w; fh_next = rd_h;
              fign_next  = {1'b0, req_slot};
              state_next = S_FIT_EFF;
            end
          end
          OP_ROTATE: begin
            if (!rotation_enabled) begin
              res_next = pack_fail(ST_ROT);
            end else if (!have) begin
              res_next = pack_fail(ST_BAD);
            end else if (!req_rot) begin
              res_next = pack_fail(ST_ROT);
            end else begin
              fx_next = rd_x; fy_next = rd_y; fw_next = rd_h; fh_next = rd_w;
              fign_next  = {1'b0, req_slot};
              state_next = S_FIT_EFF;
            end
          end
          OP_QUERY: begin
            if (list_mode || ({1'b0, req_x} >= gw) || ({1'b0, req_y} >= gh)) begin
              res_next = pack_fail(ST_EMPTY);
            end else begin
              state_next = S_Q_RD;
            end
          end
          default: res_next = pack_fail(ST_BAD);
        endcase
      end
      S_FIT_EFF: begin
        few_next   = eff_size(fw, size_scale);
        feh_next   = eff_size(fh, size_scale);
        state_next = S_FIT_BND;
      end
      S_FIT_BND: begin
        dx_next = '0;
        dy_next = '0;
        if (list_mode) begin
          fit_ok_next = 1'b1;
          state_next  = S_POST;
        end else if (({2'd0, fx} + {1'b0, few} > {1'b0, gw}) ||
                     ({2'd0, fy} + {1'b0, feh} > {1'b0, gh})) begin
          fit_ok_next = 1'b0;
          state_next  = S_POST;
        end else begin
          state_next = S_FIT_RD;
        end
      end
      S_FIT_RD: begin
        map_raddr  = {fy + dy[GY_W-1:0], fx + dx[GX_W-1:0]};
        state_next = S_FIT_CHK;
      end
      S_FIT_CHK: begin
        if ((own != '0) && ((own - 1'b1) != fign)) begin
          fit_ok_next = 1'b0;
          state_next  = S_POST;
        end else if (dx == few - 5'd1) begin
          dx_next = '0;
          if (dy == feh - 5'd1) begin
            fit_ok_next = 1'b1;
            state_next  = S_POST;
          end else begin
            dy_next    = dy + 5'd1;
            state_next = S_FIT_RD;
          end
        end else begin
          dx_next    = dx + 5'd1;
          state_next = S_FIT_RD;
        end
      end
      S_POST: begin
        state_next = S_EMIT;
        case (req_op)
          OP_PLACE: begin
            if (fit_ok) begin
              rect_we    = 1'b1;
              rect_waddr = free_slot;
              rect_wdata = {fx, fy, req_w, req_h};
              valid_next[free_slot] = 1'b1;
              dirty_next = 1'b1;
              res_next   = pack_ok(free_slot, fx, fy, req_w, req_h);
            end else if (!scanning) begin
              if ((few <= gw) && (feh <= gh)) begin
                scanning_next = 1'b1;
                fx_next    = '0;
                fy_next    = '0;
                state_next = S_FIT_BND;
              end else begin
                res_next = pack_fail(ST_NO_ROOM);
              end
            end else if ({2'd0, fx} + 6'd1 + {1'b0, few} <= {1'b0, gw}) begin
              fx_next    = fx + 1'b1;
              state_next = S_FIT_BND;
            end else if ({2'd0, fy} + 6'd1 + {1'b0, feh} <= {1'b0, gh}) begin
              fx_next    = '0;
              fy_next    = fy + 1'b1;
              state_next = S_FIT_BND;
            end else begin
              res_next = pack_fail(ST_NO_ROOM);
            end
          end
          OP_MOVE: begin
            if (fit_ok) begin
              rect_we    = 1'b1;
              rect_wdata = {req_x, req_y, tw, th};
              dirty_next = 1'b1;
              res_next   = pack_ok(req_slot, req_x, req_y, tw, th);
            end else begin
              res_next = pack_fail(ST_NO_ROOM);
            end
          end
          OP_ROTATE: begin
            if (fit_ok) begin
              rect_we    = 1'b1;
              rect_wdata = {tx, ty, th, tw};
              dirty_next = 1'b1;
              res_next   = pack_ok(req_slot, tx, ty, th, tw);
            end else begin
              res_next = pack_fail(ST_NO_ROOM);
            end
          end
          default: res_next = pack_fail(ST_BAD);
        endcase
      end
      S_Q_RD: begin
        map_raddr  = {req_y, req_x};
        state_next = S_Q_TBL;
      end
      S_Q_TBL: begin
        q_slot_next = SLOT_W'(own - 1'b1);
        rect_raddr  = SLOT_W'(own - 1'b1);
        if ((own == '0) || !valid[SLOT_W'(own - 1'b1)]) begin
          res_next   = pack_fail(ST_EMPTY);
          state_next = S_EMIT;
        end else begin
          state_next = S_Q_DONE;
        end
      end
      S_Q_DONE: begin
        res_next   = pack_ok(q_slot, rd_x, rd_y, rd_w, rd_h);
        state_next = S_EMIT;
      end
      // hand the result to the output register once it is free
      S_EMIT: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      dirty     <= 1'b1;
      out_valid <= 1'b0;
      grid_width       <= 5'd0;
      grid_height      <= 5'd0;
      size_scale       <= 9'd256;
      rotation_enabled <= 1'b1;
    end else begin
      valid     <= valid_next;
      dirty     <= dirty_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_W: grid_width       <= cfg_data[4:0];
          REG_GRID_H: grid_height      <= cfg_data[4:0];
          REG_SCALE:  size_scale       <= cfg_data;
          REG_ROT_EN: rotation_enabled <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_op <= req_op_next; req_slot <= req_slot_next;
    req_x <= req_x_next; req_y <= req_y_next;
    req_w <= req_w_next; req_h <= req_h_next; req_rot <= req_rot_next;
    tx <= tx_next; ty <= ty_next; tw <= tw_next; th <= th_next;
    free_slot <= free_slot_next;
    clr <= clr_next; rs <= rs_next;
    rx <= rx_next; ry <= ry_next; rew <= rew_next; reh <= reh_next;
    dx <= dx_next; dy <= dy_next;
    fx <= fx_next; fy <= fy_next; fw <= fw_next; fh <= fh_next;
    few <= few_next; feh <= feh_next; fign <= fign_next;
    fit_ok <= fit_ok_next; scanning <= scanning_next; q_slot <= q_slot_next;
    res <= res_next; out_data <= out_data_next;
  end

endmodule

>>> hdl/grfa_checker.sv
// ----------------------------------------------------------------------------
// grfa_checker
// Port-level checks on the allocator result stream.
// ----------------------------------------------------------------------------
module grfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  // a failed request carries no rectangle
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[2:0] != 3'd0) |-> (m_axis_tdata[31:3] == 29'd0))
    else $error("failed result carries data");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a request is taken only while the block is between requests
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted back to back");

endmodule

bind grid_rect_first_fit_allocator grfa_checker u_grfa_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> tb/tb_grid_rect_first_fit_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_rect_first_fit_allocator
// Drives place, remove, move, rotate and cell-query requests through the
// stream port under several grid settings, predicts each result with an own
// slot table and owner map, and compares every result field by field.
// ----------------------------------------------------------------------------
import grfa_pkg::*;

class rect_tracker;
  bit          vld [MAX_RECTS];
  int          rx [MAX_RECTS];
  int          ry [MAX_RECTS];
  int          rw [MAX_RECTS];
  int          rh [MAX_RECTS];
  int          owner [CELLS];
  int          grid_w_reg;
  int          grid_h_reg;
  int          scale_reg;
  bit          rot_en_reg;
  logic [28:0] due [$];
  int          errors;

  function new();
    grid_w_reg = 0;
    grid_h_reg = 0;
    scale_reg  = 256;
    rot_en_reg = 1;
    errors     = 0;
    foreach (vld[i]) vld[i] = 0;
  endfunction

  function void set_reg(reg_idx_t idx, int val);
    case (idx)
      REG_GRID_W: grid_w_reg = val & 31;
      REG_GRID_H: grid_h_reg = val & 31;
      REG_SCALE:  scale_reg  = val & 511;
      default:    rot_en_reg = val & 1;
    endcase
  endfunction

  function int ncols();
    return (grid_w_reg > MAX_GRID_W) ? MAX_GRID_W : grid_w_reg;
  endfunction

  function int nrows();
    return (grid_h_reg > MAX_GRID_H) ? MAX_GRID_H : grid_h_reg;
  endfunction

  function bit list_mode();
    return ncols() == 0 || nrows() == 0;
  endfunction

  // scaled footprint with the factor clamped and a floor of one cell
  function int foot(int s);
    int k;
    int e;
    k = scale_reg;
    if (k < 26) k = 26;
    if (k > 256) k = 256;
    e = ((s & 31) * k + 128) >> 8;
    return (e == 0) ? 1 : e;
  endfunction

  // paint valid slots in ascending order; higher slots win shared cells
  function void paint_map();
    int gw;
    int gh;
    gw = ncols();
    gh = nrows();
    foreach (owner[i]) owner[i] = 0;
    if (list_mode()) return;
    for (int s = 0; s < MAX_RECTS; s++) begin
      if (!vld[s]) continue;
      for (int dy = 0; dy < foot(rh[s]); dy++)
        for (int dx = 0; dx < foot(rw[s]); dx++)
          if (ry[s] + dy < gh && rx[s] + dx < gw)
            owner[(ry[s] + dy) * gw + rx[s] + dx] = s + 1;
    end
  endfunction

  function bit room_at(int x, int y, int w, int h, int skip);
    int gw;
    int ew;
    int eh;
    int o;
    if (list_mode()) return 1;
    gw = ncols();
    ew = foot(w);
    eh = foot(h);
    if (x + ew > gw || y + eh > nrows()) return 0;
    for (int dy = 0; dy < eh; dy++)
      for (int dx = 0; dx < ew; dx++) begin
        o = owner[(y + dy) * gw + x + dx];
        if (o != 0 && o - 1 != skip) return 0;
      end
    return 1;
  endfunction

  function logic [28:0] outcome(status_t st, int s);
    if (st != ST_OK) return {26'd0, st};
    return {5'(rh[s]), 5'(rw[s]), 6'(ry[s]), 4'(rx[s]), 6'(s), ST_OK};
  endfunction

  // work out the result of one accepted request and advance the state
  function void note_request(logic [31:0] d);
    logic [2:0] op;
    int slot;
    int px;
    int py;
    int sw;
    int sh;
    bit rot;
    bit have;
    int s;
    int t;
    bit found;
    logic [28:0] r;
    op   = d[2:0];
    slot = d[8:3];
    px   = d[12:9];
    py   = d[16:13];
    sw   = d[21:17];
    sh   = d[26:22];
    rot  = d[27];
    have = vld[slot];
    found = 0;
    paint_map();
    case (op)
      OP_PLACE: begin
        for (s = 0; s < MAX_RECTS; s++)
          if (!vld[s]) break;
        if (s >= MAX_RECTS) begin
          r = outcome(ST_NO_ROOM, 0);
        end else begin
          if (room_at(px, py, sw, sh, MAX_RECTS)) begin
            found = 1;
          end else if (foot(sw) <= ncols() && foot(sh) <= nrows()) begin
            for (int y = 0; y + foot(sh) <= nrows() && !found; y++)
              for (int x = 0; x + foot(sw) <= ncols() && !found; x++)
                if (room_at(x, y, sw, sh, MAX_RECTS)) begin
                  px = x;
                  py = y;
                  found = 1;
                end
          end
          if (!found) begin
            r = outcome(ST_NO_ROOM, 0);
          end else begin
            vld[s] = 1;
            rx[s] = px;
            ry[s] = py;
            rw[s] = sw;
            rh[s] = sh;
            r = outcome(ST_OK, s);
          end
        end
      end
      OP_REMOVE: begin
        if (!have) begin
          r = outcome(ST_BAD, 0);
        end else begin
          r = outcome(ST_OK, slot);
          vld[slot] = 0;
        end
      end
      OP_MOVE: begin
        if (!have) r = outcome(ST_BAD, 0);
        else if (!room_at(px, py, rw[slot], rh[slot], slot)) r = outcome(ST_NO_ROOM, 0);
        else begin
          rx[slot] = px;
          ry[slot] = py;
          r = outcome(ST_OK, slot);
        end
      end
      OP_ROTATE: begin
        if (!rot_en_reg) r = outcome(ST_ROT, 0);
        else if (!have) r = outcome(ST_BAD, 0);
        else if (!rot) r = outcome(ST_ROT, 0);
        else if (!room_at(rx[slot], ry[slot], rh[slot], rw[slot], slot))
          r = outcome(ST_NO_ROOM, 0);
        else begin
          t = rw[slot];
          rw[slot] = rh[slot];
          rh[slot] = t;
          r = outcome(ST_OK, slot);
        end
      end
      OP_QUERY: begin
        if (list_mode() || px >= ncols() || py >= nrows()) r = outcome(ST_EMPTY, 0);
        else if (owner[py * ncols() + px] == 0) r = outcome(ST_EMPTY, 0);
        else r = outcome(ST_OK, owner[py * ncols() + px] - 1);
      end
      default: r = outcome(ST_BAD, 0);
    endcase
    due.push_back(r);
  endfunction

  task flag(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [31:0] d);
    logic [28:0] e;
    if (due.size() == 0) begin
      flag($sformatf("unexpected result %h", d));
      return;
    end
    e = due.pop_front();
    if (d[2:0] != e[2:0])     flag($sformatf("status %0d, want %0d", d[2:0], e[2:0]));
    if (d[8:3] != e[8:3])     flag($sformatf("slot %0d, want %0d", d[8:3], e[8:3]));
    if (d[12:9] != e[12:9])   flag($sformatf("x %0d, want %0d", d[12:9], e[12:9]));
    if (d[18:13] != e[18:13]) flag($sformatf("y %0d, want %0d", d[18:13], e[18:13]));
    if (d[23:19] != e[23:19]) flag($sformatf("w %0d, want %0d", d[23:19], e[23:19]));
    if (d[28:24] != e[28:24]) flag($sformatf("h %0d, want %0d", d[28:24], e[28:24]));
  endtask

  // mostly a live slot so remove, move and rotate get past the slot check
  function int pick_slot();
    int live [$];
    foreach (vld[i]) if (vld[i]) live.push_back(i);
    if (live.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, MAX_RECTS - 1);
    return live[$urandom_range(0, live.size() - 1)];
  endfunction
endclass

module tb_grid_rect_first_fit_allocator;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int         WATCHDOG     = 400000;
  localparam int         SETTLE       = 1500;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  rect_tracker book;
  int          burst_left;
  int          quiet_cycles;
  int          stall_mode;
  int          stall_left;

  grid_rect_first_fit_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one request and hold it until the transaction; then either keep
  // the burst going or drop tvalid for a random gap.
  task send_req(logic [2:0] op, int slot, int px, int py, int sw, int sh, bit rot);
    int gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, rot, 5'(sh), 5'(sw), 4'(py), 4'(px), 6'(slot), op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_request(s_axis_tdata);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drop tvalid, wait for every expected result, then idle a while before
  // anything else happens.
  task drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 9'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    book.set_reg(idx, val);
  endtask

  task set_grid(int gw, int gh, int scale, bit rot_en);
    drain();
    write_reg(REG_GRID_W, gw);
    write_reg(REG_GRID_H, gh);
    write_reg(REG_SCALE, scale);
    write_reg(REG_ROT_EN, rot_en);
  endtask

  // Mostly small footprints; now and then any 5-bit size, zero included.
  function int rand_size();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 31);
    return $urandom_range(1, 6);
  endfunction

  task random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      send_req(OP_PLACE, $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 15),
               rand_size(), rand_size(), $urandom_range(0, 1));
    else if (pick < 50)
      send_req(OP_REMOVE, book.pick_slot(), $urandom_range(0, 15), $urandom_range(0, 15),
               rand_size(), rand_size(), $urandom_range(0, 1));
    else if (pick < 68)
      send_req(OP_MOVE, book.pick_slot(), $urandom_range(0, 15), $urandom_range(0, 15),
               rand_size(), rand_size(), $urandom_range(0, 1));
    else if (pick < 83)
      send_req(OP_ROTATE, book.pick_slot(), $urandom_range(0, 15), $urandom_range(0, 15),
               rand_size(), rand_size(), $urandom_range(0, 5) != 0);
    else if (pick < 97)
      send_req(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 15),
               rand_size(), rand_size(), $urandom_range(0, 1));
    else
      send_req(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom_range(0, 63),
               $urandom_range(0, 15), $urandom_range(0, 15), rand_size(), rand_size(),
               $urandom_range(0, 1));
  endtask

  // Receiver: switch at random between always ready, random stalls and long stalls,
  // drawing a new mode whenever the stall_left countdown runs out.
  always @(negedge clk) begin
    if (stall_left <= 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= $urandom_range(0, 9) < 7;
      default: m_axis_tready <= $urandom_range(0, 7) == 0;
    endcase
  end

  // Check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
  end

  // Watchdog: end the run after too long without any transaction.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int gw_set [8] = '{16, 8, 16, 31, 3, 0, 12, 16};
    int gh_set [8] = '{16, 5, 16, 31, 16, 9, 10, 16};
    int sc_set [8] = '{256, 128, 26, 511, 300, 256, 200, 13};
    bit re_set [8] = '{1, 1, 0, 1, 1, 1, 1, 1};
    book          = new();
    burst_left    = 1;
    quiet_cycles  = 0;
    stall_mode    = 0;
    stall_left    = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_GRID_W;
    cfg_data      = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // List mode straight out of reset: anything fits, queries find nothing.
    send_req(OP_PLACE, 0, 15, 15, 16, 16, 1);
    send_req(OP_PLACE, 63, 0, 0, 0, 31, 0);
    send_req(OP_QUERY, 0, 0, 0, 1, 1, 0);
    send_req(OP_ROTATE, 0, 0, 0, 1, 1, 0);
    send_req(OP_ROTATE, 0, 0, 0, 1, 1, 1);
    send_req(OP_MOVE, 1, 7, 9, 1, 1, 0);
    send_req(OP_MOVE, 5, 3, 3, 1, 1, 0);
    send_req(OP_REMOVE, 40, 0, 0, 1, 1, 0);
    send_req(OP_UNUSED_LO, 0, 0, 0, 1, 1, 0);
    send_req(3'd6, 0, 0, 0, 1, 1, 0);
    send_req(OP_UNUSED_HI, 63, 15, 15, 31, 31, 1);
    // fill every slot so a place with no free slot shows up
    for (int i = 0; i < MAX_RECTS + 1; i++) send_req(OP_PLACE, 0, i & 15, i >> 2, 2, 3, 1);
    // hold off the sender until the block has caught up completely
    drain();
    for (int i = 0; i < MAX_RECTS; i += 2) send_req(OP_REMOVE, i, 0, 0, 1, 1, 0);

    // Full grid: requested spot, first-fit fallback, overlap and clipping.
    set_grid(16, 16, 256, 1);
    send_req(OP_PLACE, 0, 0, 0, 16, 16, 1);
    send_req(OP_PLACE, 0, 15, 15, 1, 1, 1);
    send_req(OP_QUERY, 0, 15, 15, 1, 1, 0);
    send_req(OP_QUERY, 0, 0, 0, 1, 1, 0);
    send_req(OP_MOVE, 1, 15, 0, 1, 1, 0);
    send_req(OP_ROTATE, 1, 0, 0, 1, 1, 1);
    for (int i = 1; i < MAX_RECTS; i += 2) send_req(OP_REMOVE, i, 0, 0, 1, 1, 0);
    send_req(OP_PLACE, 0, 14, 14, 4, 2, 1);
    send_req(OP_ROTATE, 0, 0, 0, 1, 1, 1);
    send_req(OP_PLACE, 0, 0, 0, 16, 16, 1);

    set_grid(16, 16, 256, 0);
    send_req(OP_ROTATE, 0, 0, 0, 1, 1, 1);

    for (int p = 0; p < 8; p++) begin
      set_grid(gw_set[p], gh_set[p], sc_set[p], re_set[p]);
      for (int n = 0; n < 150; n++) random_req();
    end

    drain();
    if (book.due.size() != 0) book.flag("results still expected at the end");
    if (book.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
